// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at each rising clock edge, masked while reset is low.
`define CRA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked at each rising clock edge, masked in reset.
`define CRA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: rtl/core/cra_pkg.sv
// Package for the contiguous region allocator: unit codes, operation and
// status codes, policy codes, and the command and status structs.
// Depends on nothing.
`default_nettype none
package cra_pkg;
  localparam int UNITS_DEF = 256;

  localparam logic [1:0] U_FREE  = 2'd0;
  localparam logic [1:0] U_START = 2'd1;
  localparam logic [1:0] U_CONT  = 2'd2;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_HOLE = 2'd1;
  localparam logic [1:0] ST_NO_REG  = 2'd2;

  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_BEST   = 2'd1;
  localparam logic [1:0] POL_WORST  = 2'd2;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic init;    // clearing pass after reset
    logic clear;   // reset scan counters, latch operation
    logic scan;    // step the read/analyze pass
    logic write;   // step the write-back pass
    logic count;   // step the counting pass
  } cra_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;   // last step of the current pass
    logic need_write;  // operation needs the write-back pass
  } cra_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/cra_ctrl.sv
// Controller state machine for the region allocator: sequences the clearing,
// scan, write-back and count passes and runs the in/out handshake.
// Depends on cra_pkg.
`default_nettype none
module cra_ctrl
  import cra_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output cra_cmd_t       cmd,
  input  wire cra_stat_t stat
);
  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WRITE = 6'b001000,
    S_COUNT = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Commands follow the state
  always_comb begin
    cmd.init  = (state_r == S_INIT);
    cmd.clear = (state_r == S_IDLE) && in_valid;
    cmd.scan  = (state_r == S_SCAN);
    cmd.write = (state_r == S_WRITE);
    cmd.count = (state_r == S_COUNT);
  end

  // Advance through the passes
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:  if (stat.scan_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (stat.scan_last) state_nxt = stat.need_write ? S_WRITE : S_COUNT;
      S_WRITE: if (stat.scan_last) state_nxt = S_COUNT;
      S_COUNT: if (stat.scan_last) state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/cra_dp.sv
// Datapath for the region allocator: unit map memory with a registered read
// port, scan pass (placement search, release, in-place compaction), write
// pass and counting pass. Depends on cra_pkg.
`default_nettype none
module cra_dp
  import cra_pkg::*;
#(
  parameter int UNITS = UNITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cra_cmd_t    cmd,
  output cra_stat_t        stat,
  input  wire logic [1:0]  policy,
  input  wire logic [1:0]  operation,
  input  wire logic [8:0]  request_size,
  input  wire logic [7:0]  region_index,
  output logic [1:0]       status,
  output logic [7:0]       region_start,
  output logic [8:0]       region_count,
  output logic [8:0]       hole_count
);
  localparam int AW = $clog2(UNITS);
  localparam int CW = AW + 1;
  // Wide enough for UNITS and for a 9-bit request
  localparam int LW = (CW > 9) ? CW : 9;
  localparam logic [AW-1:0] LAST_ADDR = AW'(UNITS - 1);
  localparam logic [CW-1:0] UNITS_C   = CW'(UNITS);

  // Map storage: one registered read and one write per cycle
  logic [1:0] mem [UNITS];
  logic [1:0] rd_r;

  // Read stream: address issued, then the data follows in the next cycle
  logic [AW-1:0] addr_r;
  logic          rd_go_r;
  logic          dv_r;
  logic [AW-1:0] da_r;

  // Latched operation
  logic [1:0]    op_r;
  logic [1:0]    pol_r;
  logic [8:0]    size_r;
  logic [7:0]    idx_r;

  // Scan state
  logic [LW-1:0] run_len_r;
  logic [AW-1:0] run_start_r;
  logic          found_r;
  logic [LW-1:0] best_len_r;
  logic [AW-1:0] best_pos_r;
  logic [LW-1:0] seen_r;
  logic          rel_hit_r;
  logic          rel_on_r;     // inside the region being freed
  logic [CW-1:0] wp_r;         // compaction write pointer

  // Write pass
  logic [AW-1:0] wa_r;
  logic [LW-1:0] wcnt_r;
  logic          wfirst_r;

  // Count pass and results
  logic [1:0]    prev_r;
  logic [CW-1:0] regs_r;
  logic [CW-1:0] holes_r;
  logic [1:0]    status_r;
  logic [7:0]    start_r;
  logic [1:0]    status_nxt;
  logic [7:0]    start_nxt;

  logic [1:0]    cur;
  logic          dlast;
  logic          close_now;
  logic [LW-1:0] rl_eff;
  logic [AW-1:0] rs_eff;
  logic          take;
  logic [AW-1:0] pos_fin;
  logic          found_fin;
  logic          rel_now;
  logic [CW-1:0] wp_fin;
  logic          need_write;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [1:0]    mem_wd;

  assign cur   = rd_r;
  assign dlast = (da_r == LAST_ADDR);

  // Hole close test at a non-free unit or at the map end
  always_comb begin
    close_now = dv_r && ((cur != U_FREE) || dlast);
    rl_eff = (cur == U_FREE) ? run_len_r + LW'(1) : run_len_r;
    rs_eff = (cur == U_FREE && run_len_r == '0) ? da_r : run_start_r;
    take = 1'b0;
    if (close_now && size_r != '0 && rl_eff >= LW'(size_r)) begin
      case (pol_r)
        POL_BEST:  take = !found_r || rl_eff < best_len_r;
        POL_WORST: take = !found_r || rl_eff > best_len_r;
        default:   take = !found_r;
      endcase
    end
    pos_fin   = take ? rs_eff : best_pos_r;
    found_fin = found_r || take;
    rel_now   = dv_r && cur == U_START && !rel_hit_r && seen_r == LW'(idx_r);
    wp_fin    = wp_r + ((cur != U_FREE) ? CW'(1) : CW'(0));
  end

  // Pass status for the controller
  always_comb begin
    case (op_r)
      OP_ALLOC:   need_write = found_fin;
      OP_COMPACT: need_write = (wp_fin < UNITS_C);
      default:    need_write = 1'b0;
    endcase
    if (cmd.init) stat.scan_last = (addr_r == LAST_ADDR);
    else if (cmd.write) stat.scan_last = (wcnt_r == LW'(1));
    else stat.scan_last = dv_r && dlast;
    stat.need_write = need_write;
  end

  // Result fields taken at the end of the scan
  always_comb begin
    status_nxt = ST_DONE;
    start_nxt  = '0;
    case (op_r)
      OP_ALLOC: begin
        if (found_fin) start_nxt = 8'(pos_fin);
        else status_nxt = ST_NO_HOLE;
      end
      OP_RELEASE: if (!(rel_hit_r || rel_now)) status_nxt = ST_NO_REG;
      default: status_nxt = ST_DONE;
    endcase
  end

  // Write port: clearing, placement fill, release and compaction moves
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = U_FREE;
    if (cmd.init) begin
      mem_we = 1'b1;
      mem_wa = addr_r;
    end else if (cmd.write) begin
      mem_we = 1'b1;
      mem_wa = wa_r;
      if (op_r == OP_ALLOC) mem_wd = wfirst_r ? U_START : U_CONT;
    end else if (cmd.scan && dv_r) begin
      case (op_r)
        OP_RELEASE: begin
          if (rel_now || (rel_on_r && cur == U_CONT)) begin
            mem_we = 1'b1;
            mem_wa = da_r;
          end
        end
        OP_COMPACT: begin
          if (cur != U_FREE) begin
            mem_we = 1'b1;
            mem_wa = AW'(wp_r);
            mem_wd = cur;
          end
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Memory access; writes never hit an address still to be read in a pass
  always_ff @(posedge clk) begin
    rd_r <= mem[addr_r];
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // Advance the read address over one pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      rd_go_r <= 1'b1;
      dv_r    <= 1'b0;
    end else if (cmd.init) begin
      addr_r <= (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
      dv_r   <= 1'b0;
    end else if (cmd.clear) begin
      addr_r  <= '0;
      rd_go_r <= 1'b1;
      dv_r    <= 1'b0;
    end else if (cmd.scan || cmd.count) begin
      dv_r <= rd_go_r;
      da_r <= addr_r;
      if (rd_go_r) begin
        if (addr_r == LAST_ADDR) begin
          addr_r  <= '0;
          rd_go_r <= 1'b0;
        end else begin
          addr_r <= addr_r + AW'(1);
        end
      end else if (dv_r && dlast) begin
        rd_go_r <= 1'b1;
      end
    end else begin
      dv_r <= 1'b0;
    end
  end

  // Per-operation state for the scan, write and count passes
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      op_r        <= operation;
      pol_r       <= policy;
      size_r      <= request_size;
      idx_r       <= region_index;
      run_len_r   <= '0;
      run_start_r <= '0;
      found_r     <= 1'b0;
      best_len_r  <= '0;
      best_pos_r  <= '0;
      seen_r      <= '0;
      rel_hit_r   <= 1'b0;
      rel_on_r    <= 1'b0;
      wp_r        <= '0;
      wfirst_r    <= 1'b1;
      prev_r      <= U_START;
      regs_r      <= '0;
      holes_r     <= '0;
    end else if (cmd.scan && dv_r) begin
      // Free-run tracking for placement
      if (cur == U_FREE) begin
        if (run_len_r == '0) run_start_r <= da_r;
        run_len_r <= run_len_r + LW'(1);
      end else begin
        run_len_r <= '0;
      end
      if (take) begin
        found_r    <= 1'b1;
        best_len_r <= rl_eff;
        best_pos_r <= rs_eff;
      end
      // Region ordinal search for release
      if (rel_now) begin
        rel_hit_r <= 1'b1;
        rel_on_r  <= 1'b1;
      end else if (!(rel_on_r && cur == U_CONT)) begin
        rel_on_r <= 1'b0;
      end
      if (cur == U_START) seen_r <= seen_r + LW'(1);
      // Pack survivors for compaction
      if (cur != U_FREE) wp_r <= wp_r + CW'(1);
      // Settle results and set up the write pass
      if (dlast) begin
        status_r <= status_nxt;
        start_r  <= start_nxt;
        wa_r     <= (op_r == OP_ALLOC) ? pos_fin : AW'(wp_fin);
        wcnt_r   <= (op_r == OP_ALLOC) ? LW'(size_r) : LW'(UNITS_C - wp_fin);
      end
    end else if (cmd.write) begin
      wa_r     <= wa_r + AW'(1);
      wcnt_r   <= wcnt_r - LW'(1);
      wfirst_r <= 1'b0;
    end else if (cmd.count && dv_r) begin
      prev_r <= cur;
      if (cur == U_START) regs_r <= regs_r + CW'(1);
      if (cur == U_FREE && prev_r != U_FREE) holes_r <= holes_r + CW'(1);
    end
  end

  assign status       = status_r;
  assign region_start = start_r;
  assign region_count = 9'(regs_r);
  assign hole_count   = 9'(holes_r);
endmodule
`default_nettype wire

// File: rtl/core/contiguous_region_allocator_unit.sv
// Contiguous region allocator: one operation (allocate, release, compact)
// per input transfer over a map of UNITS units. After reset a clearing pass
// writes every unit free, with the input stalled. An operation then runs a
// scan pass, a write-back pass over k units when k is not 0, and a count
// pass; the result is offered after the count pass, and a new input is
// taken only after the result has been taken. k is the request size for
// a successful allocate, the number of free units for a compaction that
// leaves any, and 0 otherwise; the unit map has a single read and a single
// write port, and each pass steps one address per cycle. The input
// stalls while an operation is in flight; fit_policy is accepted only while
// idle with no input waiting.
// Depends on cra_pkg, cra_ctrl and cra_dp.
`default_nettype none
module contiguous_region_allocator_unit
  import cra_pkg::*;
#(
  parameter int UNITS = UNITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [8:0] in_request_size,
  input  wire logic [7:0] in_region_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output logic [7:0]      out_region_start,
  output logic [8:0]      out_region_count,
  output logic [8:0]      out_hole_count,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_fit_policy
);
  cra_cmd_t  cmd;
  cra_stat_t stat;
  logic [1:0] policy_r;

  // Accept a policy write only with nothing in flight
  assign cfg_ready = !in_stall && !in_valid;

  // Hold the placement policy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      policy_r <= cfg_fit_policy;
    end
  end

  cra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  cra_dp #(.UNITS(UNITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .policy(policy_r),
    .operation(in_operation), .request_size(in_request_size),
    .region_index(in_region_index), .status(out_status),
    .region_start(out_region_start), .region_count(out_region_count),
    .hole_count(out_hole_count)
  );
endmodule
`default_nettype wire

// File: rtl/core/cra_checker.sv
// Port-level checker for the region allocator, bound to the top level.
// Depends on assert_macros.svh and cra_pkg.
`default_nettype none
`include "assert_macros.svh"
module cra_checker
  import cra_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_region_start
);
  // One operation in flight: no input transfer while a result waits
  `CRA_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, in_stall)
  // An input transfer makes the block busy on the next cycle
  `CRA_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)
  // No back-to-back results: never a result right after a result transfer
  `CRA_ASSERT_NEXT(a_no_back_out, clk, rst_n, out_valid && !out_stall, !out_valid)
  // Failed operations place nothing
  `CRA_ASSERT_IMPL(a_fail_start, clk, rst_n, out_valid && out_status != ST_DONE,
                   out_region_start == 8'd0)
  // Status is never the unused code
  `CRA_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status <= ST_NO_REG)
endmodule

bind contiguous_region_allocator_unit cra_checker u_cra_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_region_start(out_region_start)
);
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for contiguous_region_allocator_unit: random and directed
// allocate/release/compact traffic checked against an in-bench map model.
// Depends on cra_pkg and the allocator RTL.
`default_nettype none
module tb_top
  import cra_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUNITS = 256;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] start;
    logic [8:0] regions;
    logic [8:0] holes;
  } alloc_result_t;

  // Map model plus queue of predicted allocator results
  class alloc_scoreboard;
    logic [1:0] umap [NUNITS];
    logic [1:0] policy;
    alloc_result_t pending [$];
    int mismatches;

    function void clear_map();
      foreach (umap[i]) umap[i] = U_FREE;
      policy = POL_FIRST;
      mismatches = 0;
    endfunction

    function bit find_hole(int size, output int pos);
      bit found;
      int best_len, run_start, run_len;
      bit take;
      found = 0; best_len = 0; run_start = 0; run_len = 0; pos = 0;
      if (size == 0) return 0;
      for (int i = 0; i <= NUNITS; i++) begin
        if (i < NUNITS && umap[i] == U_FREE) begin
          if (run_len == 0) run_start = i;
          run_len++;
        end else begin
          if (run_len >= size) begin
            if (policy == POL_BEST) take = !found || run_len < best_len;
            else if (policy == POL_WORST) take = !found || run_len > best_len;
            else take = !found;
            if (take) begin
              found = 1; best_len = run_len; pos = run_start;
            end
          end
          run_len = 0;
        end
      end
      return found;
    endfunction

    function void note_input(logic [1:0] op, logic [8:0] size, logic [7:0] idx);
      alloc_result_t r;
      int pos, seen, w, i;
      bit hit;
      r = '0;
      if (op == OP_ALLOC) begin
        if (find_hole(size, pos)) begin
          umap[pos] = U_START;
          for (i = 1; i < size; i++) umap[pos + i] = U_CONT;
          r.start = pos[7:0];
        end else r.status = ST_NO_HOLE;
      end else if (op == OP_RELEASE) begin
        hit = 0; seen = 0;
        for (i = 0; i < NUNITS && !hit; i++) begin
          if (umap[i] == U_START) begin
            if (seen == idx) begin
              hit = 1;
              umap[i] = U_FREE;
              for (int j = i + 1; j < NUNITS && umap[j] == U_CONT; j++) umap[j] = U_FREE;
            end
            seen++;
          end
        end
        if (!hit) r.status = ST_NO_REG;
      end else if (op == OP_COMPACT) begin
        w = 0;
        for (i = 0; i < NUNITS; i++)
          if (umap[i] != U_FREE) begin
            umap[w] = umap[i];
            w++;
          end
        for (; w < NUNITS; w++) umap[w] = U_FREE;
      end
      for (i = 0; i < NUNITS; i++) begin
        if (umap[i] == U_START) r.regions++;
        if (umap[i] == U_FREE && (i == 0 || umap[i-1] != U_FREE)) r.holes++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch st/start/reg/holes: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   exp.status, exp.start, exp.regions, exp.holes,
                   got.status, got.start, got.regions, got.holes);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [8:0] in_request_size = '0;
  logic [7:0] in_region_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_region_start;
  logic [8:0] out_region_count;
  logic [8:0] out_hole_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_fit_policy = '0;

  alloc_scoreboard board = new();
  int gap_left = 0;
  int burst_left = 0;

  always #10 clk = ~clk;

  contiguous_region_allocator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_request_size(in_request_size), .in_region_index(in_region_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_region_start(out_region_start), .out_region_count(out_region_count),
    .out_hole_count(out_hole_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_fit_policy(cfg_fit_policy)
  );

  // Check each result transfer at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_status, out_region_start, out_region_count, out_hole_count});
  end

  // Receiver stall pattern: quiet stretches alternate with random stalls
  always @(negedge clk) begin
    if ((($time / 20) % 4000) < 1000) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Present one operation, holding it until accepted; operations come in bursts separated by gaps
  task automatic send_op(input logic [1:0] op, input logic [8:0] size,
                         input logic [7:0] idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
    end
    while (gap_left > 0) begin
      @(negedge clk);
      gap_left--;
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_size <= size;
    in_region_index <= idx;
    do @(posedge clk); while (in_stall);
    board.note_input(op, size, idx);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the clock run on idle
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (3 * NUNITS + 10) @(posedge clk);
  endtask

  task automatic write_policy(input logic [1:0] pol);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_fit_policy <= pol;
    do @(posedge clk); while (!cfg_ready);
    board.policy = pol;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly allocations and releases with small sizes, some noise
  task automatic random_op();
    int pick;
    logic [8:0] sz;
    pick = $urandom_range(0, 99);
    if (pick < 3) sz = 9'($urandom_range(0, 511));
    else if (pick < 8) sz = 9'($urandom_range(64, 256));
    else sz = 9'($urandom_range(1, 24));
    pick = $urandom_range(0, 99);
    if (pick < 50) send_op(OP_ALLOC, sz, 8'($urandom()));
    else if (pick < 85)
      send_op(OP_RELEASE, 9'($urandom()),
              8'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 15)));
    else if (pick < 97) send_op(OP_COMPACT, 9'($urandom()), 8'($urandom()));
    else send_op(OP_UNUSED, 9'($urandom()), 8'($urandom()));
  endtask

  initial begin
    board.clear_map();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation, special cases
    send_op(OP_ALLOC, 9'd0, 8'd0);
    send_op(OP_ALLOC, 9'd257, 8'd0);
    send_op(OP_ALLOC, 9'd511, 8'd255);
    send_op(OP_ALLOC, 9'd256, 8'd0);
    send_op(OP_ALLOC, 9'd1, 8'd0);
    send_op(OP_RELEASE, 9'd0, 8'd1);
    send_op(OP_RELEASE, 9'd0, 8'd255);
    send_op(OP_RELEASE, 9'd0, 8'd0);
    send_op(OP_ALLOC, 9'd10, 8'd0);
    send_op(OP_ALLOC, 9'd20, 8'd0);
    send_op(OP_ALLOC, 9'd5, 8'd0);
    send_op(OP_RELEASE, 9'd0, 8'd0);
    send_op(OP_RELEASE, 9'd0, 8'd1);
    send_op(OP_UNUSED, 9'h1FF, 8'hFF);
    send_op(OP_COMPACT, 9'd0, 8'd0);
    send_op(OP_ALLOC, 9'd221, 8'd0);
    send_op(OP_ALLOC, 9'd30, 8'd0);
    send_op(OP_RELEASE, 9'd0, 8'd0);
    drain();

    // Random phases across all policies, including the unused one
    for (int ph = 0; ph < 8; ph++) begin
      write_policy((ph == 7) ? POL_UNUSED : 2'(ph % 3));
      for (int k = 0; k < 135; k++) random_op();
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
